/* hw/rtl/svs_pkg.sv */
// ---------------------------------------------------------------------------
// svs_pkg: shared types and constants
// Widths, limits and sequencer states of the running variance unit.
// ---------------------------------------------------------------------------
package svs_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int SAMPLE_BITS = 16;
    localparam int COUNT_W     = 17;
    localparam int SUM_W       = 33;
    localparam int ACC_W       = 64;
    localparam int VAR_W       = 48;
    localparam int STD_W       = 24;
    localparam logic [COUNT_W-1:0] MAX_COUNT = 17'd65536;

    // deviation magnitude |n*x - T| fits 34 bits, its square 68 bits
    localparam int DEV_W = 34;
    localparam int SQ_W  = 2 * DEV_W;
    // divider widths: dividend is the square shifted by 16, divisor 34 bits
    localparam int DIVN_W = SQ_W + 16;
    localparam int DEN_W  = 34;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_SQ,
        ST_DIV,
        ST_ACC,
        ST_VDIV,
        ST_SQRT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
    } div_ctl_t;

endpackage

/* hw/rtl/streaming_variance_std_unit.sv */
// ---------------------------------------------------------------------------
// streaming_variance_std_unit: running variance and standard deviation
// Youngs-Cramer update per sample; variance, root and count on the last one.
// ---------------------------------------------------------------------------
//  channel   | direction | word contents
//  s_axis    | in        | tdata = sample[15:0], tlast = last
//  m_axis    | out       | tdata = variance, std_dev, sample_count, overflow
//
//  A later sample of a set passes from accept to the next accept through
//  a 17-step serial multiply (n*x and n*(n-1)), a 34-step serial square
//  and a radix-2 divide; a first or dropped sample skips all three. A last
//  sample adds a divisor load, divide start, a divide by the count, a
//  24-step root and the output word load, plus any wait for the previous
//  output word. Reset clears count, sum, accumulator and flag at once.
//  s_axis_tready is low while a sample is in work.
// ---------------------------------------------------------------------------
module streaming_variance_std_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [15:0]  s_axis_tdata,   // sample[15:0]
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [95:0]  m_axis_tdata    // variance[47:0], std_dev[71:48],
                                         // sample_count[88:72], overflow[89]
);
    import svs_pkg::*;

    state_t state_reg, state_next;

    logic [COUNT_W-1:0] count_reg, count_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic               ovf_reg, ovf_next;
    logic               last_reg, last_next;

    // serial multiplier: shift multiplier bits from the low end
    logic [DEV_W+SUM_W-1:0] mcand_reg, mcand_next;
    logic [DEV_W-1:0]       mplier_reg, mplier_next;
    logic [SQ_W-1:0]        prod_reg, prod_next;
    logic [6:0]             step_reg, step_next;
    logic [DEV_W-1:0]       dev_reg, dev_next;

    logic [VAR_W-1:0]  var_reg, var_next;
    logic [STD_W-1:0]  std_reg, std_next;
    logic [95:0]       out_reg, out_next;
    logic              oval_reg, oval_next;

    // root state
    logic [VAR_W+1:0]  rem_reg, rem_next;
    logic [STD_W-1:0]  root_reg, root_next;
    logic [VAR_W-1:0]  rad_reg, rad_next;

    logic [DEN_W-1:0]  den_reg, den_next;
    logic [DEN_W-1:0]  nm1_reg, nm1_next;
    div_ctl_t          div_ctl;
    logic [DIVN_W-1:0] div_dividend;
    logic              div_done;
    logic [DIVN_W-1:0] div_q;

    logic              take;
    logic signed [SAMPLE_BITS-1:0] xs;
    logic signed [SUM_W-1:0]       x_ext;
    logic [SUM_W-1:0]  sum_new;
    logic [COUNT_W-1:0] n_new;
    logic [VAR_W+1:0]  rtrial;

    svs_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .dividend (div_dividend),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign take          = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = oval_reg;
    assign m_axis_tdata  = out_reg;

    assign xs      = s_axis_tdata[SAMPLE_BITS-1:0];
    assign x_ext   = SUM_W'(xs);
    assign sum_new = sum_reg + x_ext;
    assign n_new   = count_reg + 1'b1;

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        sum_next     = sum_reg;
        acc_next     = acc_reg;
        ovf_next     = ovf_reg;
        last_next    = last_reg;
        mcand_next   = mcand_reg;
        mplier_next  = mplier_reg;
        prod_next    = prod_reg;
        step_next    = step_reg;
        dev_next     = dev_reg;
        var_next     = var_reg;
        std_next     = std_reg;
        out_next     = out_reg;
        oval_next    = oval_reg;
        rem_next     = rem_reg;
        root_next    = root_reg;
        rad_next     = rad_reg;
        den_next     = den_reg;
        nm1_next     = nm1_reg;
        div_ctl      = '{start: 1'b0};
        div_dividend = {prod_reg, 16'h0000};
        rtrial       = '0;
        if (oval_reg && m_axis_tready)
        begin
            oval_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    last_next = s_axis_tlast;
                    if (count_reg >= MAX_COUNT)
                    begin
                        ovf_next   = 1'b1;
                        state_next = s_axis_tlast ? ST_ACC : ST_IDLE;
                    end
                    else if (count_reg == '0)
                    begin
                        count_next = n_new;
                        sum_next   = x_ext;
                        state_next = s_axis_tlast ? ST_ACC : ST_IDLE;
                    end
                    else
                    begin
                        count_next  = n_new;
                        sum_next    = sum_new;
                        // n*x: multiplicand x, multiplier n
                        mcand_next  = (DEV_W+SUM_W)'(x_ext);
                        mplier_next = DEV_W'(n_new);
                        prod_next   = '0;
                        step_next   = 7'(COUNT_W);
                        // den = n*(n-1), formed serially beside n*x; n-1 is the old count
                        den_next    = '0;
                        nm1_next    = DEN_W'(count_reg);
                        state_next  = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                // accumulate n*x and n*(n-1) one multiplier bit a cycle
                if (mplier_reg[0])
                begin
                    prod_next = prod_reg + SQ_W'(mcand_reg);
                    den_next  = den_reg + nm1_reg;
                end
                mcand_next  = {mcand_reg[DEV_W+SUM_W-2:0], 1'b0};
                nm1_next    = {nm1_reg[DEN_W-2:0], 1'b0};
                mplier_next = mplier_reg >> 1;
                step_next   = step_reg - 1'b1;
                if (step_reg == 7'd1)
                begin
                    // d = n*x - T, magnitude kept
                    dev_next = prod_next[DEV_W-1:0] - {sum_reg[SUM_W-1], sum_reg};
                    if (dev_next[DEV_W-1])
                    begin
                        dev_next = -dev_next;
                    end
                    mcand_next  = (DEV_W+SUM_W)'(dev_next);
                    mplier_next = dev_next;
                    prod_next   = '0;
                    step_next   = 7'(DEV_W);
                    state_next  = ST_SQ;
                end
            end
            ST_SQ:
            begin
                if (mplier_reg[0])
                begin
                    prod_next = prod_reg + SQ_W'(mcand_reg);
                end
                mcand_next  = {mcand_reg[DEV_W+SUM_W-2:0], 1'b0};
                mplier_next = mplier_reg >> 1;
                step_next   = step_reg - 1'b1;
                if (step_reg == 7'd1)
                begin
                    state_next = ST_DIV;
                    div_ctl.start = 1'b1;
                    div_dividend  = {prod_next, 16'h0000};
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    acc_next   = acc_reg + div_q[ACC_W-1:0];
                    state_next = last_reg ? ST_ACC : ST_IDLE;
                end
            end
            ST_ACC:
            begin
                // load the count as divisor ahead of the variance divide
                den_next   = DEN_W'(count_reg);
                state_next = ST_VDIV;
            end
            ST_VDIV:
            begin
                // variance = acc / count
                div_ctl.start = 1'b1;
                div_dividend  = DIVN_W'(acc_reg);
                state_next    = ST_SQRT;
                step_next     = '0;
            end
            ST_SQRT:
            begin
                if (step_reg == '0)
                begin
                    if (div_done)
                    begin
                        var_next  = div_q[VAR_W-1:0];
                        rad_next  = div_q[VAR_W-1:0];
                        rem_next  = '0;
                        root_next = '0;
                        step_next = 7'(STD_W);
                    end
                end
                else
                begin
                    // one result bit a cycle from two radicand bits
                    rtrial   = {rem_reg[VAR_W-1:0], rad_reg[VAR_W-1:VAR_W-2]};
                    rad_next = {rad_reg[VAR_W-3:0], 2'b00};
                    if (rtrial >= (VAR_W+2)'({root_reg, 2'b01}))
                    begin
                        rem_next  = rtrial - (VAR_W+2)'({root_reg, 2'b01});
                        root_next = {root_reg[STD_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next  = rtrial;
                        root_next = {root_reg[STD_W-2:0], 1'b0};
                    end
                    step_next = step_reg - 1'b1;
                    if (step_reg == 7'd1)
                    begin
                        std_next   = root_next;
                        state_next = ST_OUT;
                    end
                end
            end
            ST_OUT:
            begin
                if (!oval_reg)
                begin
                    out_next  = {6'b0, ovf_reg, count_reg, std_reg, var_reg};
                    oval_next = 1'b1;
                    count_next = '0;
                    sum_next   = '0;
                    acc_next   = '0;
                    ovf_next   = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            sum_reg   <= '0;
            acc_reg   <= '0;
            ovf_reg   <= 1'b0;
            oval_reg  <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
            acc_reg   <= acc_next;
            ovf_reg   <= ovf_next;
            oval_reg  <= oval_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg   <= last_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        prod_reg   <= prod_next;
        dev_reg    <= dev_next;
        var_reg    <= var_next;
        std_reg    <= std_next;
        out_reg    <= out_next;
        rem_reg    <= rem_next;
        root_reg   <= root_next;
        rad_reg    <= rad_next;
        den_reg    <= den_next;
        nm1_reg    <= nm1_next;
    end

endmodule

/* hw/rtl/svs_divider.sv */
// ---------------------------------------------------------------------------
// svs_divider: radix-2 restoring divider
// Produces one quotient bit per cycle, dividend shifted in from the top.
// ---------------------------------------------------------------------------
module svs_divider (
    input  logic                         clk,
    input  logic                         rst_n,
    input  svs_pkg::div_ctl_t            ctl,
    input  logic [svs_pkg::DIVN_W-1:0]   dividend,
    input  logic [svs_pkg::DEN_W-1:0]    divisor,
    output logic                         done,
    output logic [svs_pkg::DIVN_W-1:0]   quotient
);
    import svs_pkg::*;

    localparam int CNT_W = $clog2(DIVN_W + 1);

    logic [DIVN_W-1:0] q_reg, q_next;
    logic [DEN_W:0]    r_reg, r_next;
    logic [DEN_W-1:0]  d_reg, d_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              run_reg, run_next;
    logic [DEN_W:0]    trial;
    logic [DEN_W+1:0]  diff;

    // one shift-subtract step per cycle
    always_comb
    begin
        q_next   = q_reg;
        r_next   = r_reg;
        d_next   = d_reg;
        cnt_next = cnt_reg;
        run_next = run_reg;
        trial    = {r_reg[DEN_W-1:0], q_reg[DIVN_W-1]};
        diff     = {1'b0, trial} - {2'b00, d_reg};
        if (ctl.start)
        begin
            q_next   = dividend;
            r_next   = '0;
            d_next   = divisor;
            cnt_next = CNT_W'(DIVN_W);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (!diff[DEN_W+1])
            begin
                r_next = diff[DEN_W:0];
                q_next = {q_reg[DIVN_W-2:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[DIVN_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                run_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done     = run_reg && (cnt_reg == CNT_W'(1));
    assign quotient = q_next;

endmodule
